// ===== design/imh_pkg.sv =====
`timescale 1ns / 1ps
package imh_pkg;
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_CHANGE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam int HANDLE_W = 10;
  localparam int HANDLE_LIMIT = 1024;
endpackage

// ===== design/imh_ram.sv =====
`timescale 1ns / 1ps
module imh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/indexed_min_heap_top.sv =====
`timescale 1ns / 1ps
// indexed binary min-heap with insert, extract-min and change-key commands.
// a transaction is taken when start_i is high and busy_o is low; exactly one
// result follows in the cycle in which busy_o drops, shown for that one
// cycle with done_o high. the receiver cannot stall, so it must take every
// result as it comes. keys and handles sit in one synchronous ram, the live
// bit and heap position of each handle in another, both with registered read
// data. the heap ram has one read port, so each sift-up level takes a parent
// read, then a compare and move, and each sift-down level a left child read,
// a right child read, then a compare and move. a full, empty or unknown
// command goes straight to the result. a new transaction may start in the
// cycle that shows the result. all stores come up undefined; a running
// handle counter and live bits per handle (kept in memory, written on
// insert and extract) mean nothing is read before it is written, so no
// clearing pass is needed.
module indexed_min_heap_top #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] key_in_i,
  input  logic [9:0]  handle_in_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] key_out_o,
  output logic [9:0]  handle_out_o,
  output logic [10:0] count_o
);
  import imh_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = PW + 1;
  localparam int HW = HANDLE_W;
  localparam int EW = KEY_WIDTH + HW;

  // states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;  // live/pos read returns
  localparam logic [3:0] S_CHK2   = 4'd2;  // entry at handle position returns
  localparam logic [3:0] S_RD0    = 4'd3;  // root read returns
  localparam logic [3:0] S_LASTRD = 4'd4;  // last entry read returns
  localparam logic [3:0] S_UPRD   = 4'd5;  // parent read issued
  localparam logic [3:0] S_UPCMP  = 4'd6;
  localparam logic [3:0] S_DNL    = 4'd7;  // left child read issued
  localparam logic [3:0] S_DNR    = 4'd8;  // right child read issued
  localparam logic [3:0] S_DNCMP  = 4'd9;
  localparam logic [3:0] S_PLACE  = 4'd10; // write final entry
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [HW:0]   issued_q, issued_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;     // moving entry key
  logic [HW-1:0]  hnd_q, hnd_d;           // moving entry handle
  logic [CW-1:0]  pos_q, pos_d;           // hole position
  logic [KEY_WIDTH-1:0] ck_q, ck_d;       // candidate key
  logic [HW-1:0]  ch_q, ch_d;
  logic [CW-1:0]  cp_q, cp_d;
  logic [1:0]  st_q, st_d;
  logic [31:0] ko_q, ko_d;
  logic [HW-1:0] ho_q, ho_d;
  logic [HW-1:0] hin_q, hin_d;
  logic moved_q, moved_d;                 // a change already moved up
  logic done_q, done_d;

  // heap memory: {key, handle}
  logic          hp_we;
  logic [PW-1:0] hp_wa, hp_ra;
  logic [EW-1:0] hp_wd, hp_rd;
  // handle memory: {live, position}
  logic          hd_we;
  logic [HW-1:0] hd_wa, hd_ra;
  logic [PW:0]   hd_wd, hd_rd;

  imh_ram #(.Width(EW), .Depth(CAPACITY)) u_heap (
    .clk_i, .we_i(hp_we), .waddr_i(hp_wa), .wdata_i(hp_wd),
    .raddr_i(hp_ra), .rdata_o(hp_rd)
  );
  imh_ram #(.Width(PW + 1), .Depth(HANDLE_LIMIT)) u_hdl (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd),
    .raddr_i(hd_ra), .rdata_o(hd_rd)
  );

  logic [KEY_WIDTH-1:0] rd_key;
  logic [HW-1:0] rd_hnd;
  logic [CW-1:0] par, lch, rch;
  assign rd_key = hp_rd[EW-1:HW];
  assign rd_hnd = hp_rd[HW-1:0];
  assign par = (pos_q - CW'(1)) >> 1;
  assign lch = {pos_q[CW-2:0], 1'b1};
  assign rch = lch + CW'(1);

  always_comb begin
    state_d = state_q; occ_d = occ_q; issued_d = issued_q; cmd_d = cmd_q;
    key_d = key_q; hnd_d = hnd_q; pos_d = pos_q; ck_d = ck_q; ch_d = ch_q;
    cp_d = cp_q; st_d = st_q; ko_d = ko_q; ho_d = ho_q; hin_d = hin_q;
    moved_d = moved_q; done_d = 1'b0;
    hp_we = 1'b0; hp_wa = pos_q[PW-1:0]; hp_wd = {key_q, hnd_q};
    hp_ra = '0; hd_we = 1'b0; hd_wa = hnd_q; hd_wd = {1'b1, pos_q[PW-1:0]};
    hd_ra = hin_q;
    case (state_q)
      S_IDLE: begin
        // root read for extract, handle entry read for change
        hd_ra = handle_in_i;
        if (start_i) begin
          cmd_d = cmd_i; hin_d = handle_in_i; moved_d = 1'b0;
          st_d = ST_OK; ko_d = '0; ho_d = '0;
          key_d = key_in_i[KEY_WIDTH-1:0];
          case (cmd_i)
            CMD_INSERT: begin
              if (occ_q >= CW'(CAPACITY) || issued_q >= (HW+1)'(HANDLE_LIMIT)) begin
                st_d = ST_FULL; state_d = S_DONE;
              end else begin
                hnd_d = issued_q[HW-1:0]; ho_d = issued_q[HW-1:0];
                pos_d = occ_q; occ_d = occ_q + CW'(1);
                issued_d = issued_q + (HW+1)'(1);
                state_d = S_UPRD;
              end
            end
            CMD_EXTRACT: begin
              if (occ_q == '0) begin
                st_d = ST_EMPTY; state_d = S_DONE;
              end else begin
                state_d = S_RD0;
              end
            end
            CMD_CHANGE: begin
              if ({1'b0, handle_in_i} >= issued_q) begin
                st_d = ST_BAD; state_d = S_DONE;
              end else begin
                state_d = S_CHK;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CHK: begin
        if (!hd_rd[PW] || {1'b0, hd_rd[PW-1:0]} >= occ_q) begin
          st_d = ST_BAD; state_d = S_DONE;
        end else begin
          pos_d = {1'b0, hd_rd[PW-1:0]};
          hp_ra = hd_rd[PW-1:0];
          hnd_d = hin_q;
          state_d = S_CHK2;
        end
      end
      S_CHK2: begin
        // old key back; try upward first unless at the root
        ko_d = 32'(rd_key);
        if (pos_q != '0) begin
          hp_ra = par[PW-1:0]; state_d = S_UPCMP;
        end else begin
          state_d = S_DNL;
        end
      end
      S_RD0: begin
        // root data back; retire its handle, then fetch last entry
        ko_d = 32'(rd_key); ho_d = rd_hnd;
        hd_we = 1'b1; hd_wa = rd_hnd; hd_wd = '0;
        occ_d = occ_q - CW'(1);
        hp_ra = occ_d[PW-1:0];
        pos_d = '0;
        state_d = (occ_d == '0) ? S_DONE : S_LASTRD;
      end
      S_LASTRD: begin
        key_d = rd_key; hnd_d = rd_hnd;
        state_d = S_DNL;
      end
      S_UPRD: begin
        if (pos_q == '0) begin
          state_d = S_PLACE;
        end else begin
          hp_ra = par[PW-1:0]; state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (key_q < rd_key) begin
          // move parent down into hole
          hp_we = 1'b1; hp_wd = hp_rd;
          hd_we = 1'b1; hd_wa = rd_hnd; hd_wd = {1'b1, pos_q[PW-1:0]};
          pos_d = par; moved_d = 1'b1;
          state_d = S_UPRD;
        end else if (cmd_q == CMD_CHANGE && !moved_q) begin
          // no upward move from start: try downward
          state_d = S_DNL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DNL: begin
        if (lch >= occ_q) begin
          state_d = S_PLACE;
        end else begin
          hp_ra = lch[PW-1:0];
          state_d = S_DNR;
        end
      end
      S_DNR: begin
        ck_d = rd_key; ch_d = rd_hnd; cp_d = lch;
        hp_ra = rch[PW-1:0];
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        // on a tie the right child wins
        if (rch < occ_q && !(ck_q < rd_key)) begin
          ck_d = rd_key; ch_d = rd_hnd; cp_d = rch;
        end
        if (ck_d < key_q) begin
          hp_we = 1'b1; hp_wd = {ck_d, ch_d};
          hd_we = 1'b1; hd_wa = ch_d; hd_wd = {1'b1, pos_q[PW-1:0]};
          pos_d = cp_d;
          state_d = S_DNL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        hp_we = 1'b1;
        hd_we = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; occ_q <= '0; issued_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q <= occ_d; issued_q <= issued_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; hin_q <= hin_d; moved_q <= moved_d;
    ck_q <= ck_d; ch_q <= ch_d;
    key_q <= key_d; hnd_q <= hnd_d;
    pos_q <= pos_d; cp_q <= cp_d;
    st_q <= st_d; ko_q <= ko_d; ho_q <= ho_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = st_q;
  assign key_out_o = ko_q;
  assign handle_out_o = ho_q;
  assign count_o = 11'(occ_q);

  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  ap_occ_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY)) else $error("occupancy overflow");
  ap_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
endmodule
